>>> rtl/decision_tree_classify_assert.svh
// Assertion macros shared by the classification tree RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef DECISION_TREE_CLASSIFY_ASSERT_SVH
`define DECISION_TREE_CLASSIFY_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define DTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define DTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dtc_pkg.sv
// Shared types and constants for the classification tree block.
// Depends on nothing; used by every module in rtl.
package dtc_pkg;

    localparam int NODE_BITS  = 10;
    localparam int NODES      = 1024;
    localparam int VAR_BITS   = 6;
    localparam int FEATURES   = 64;
    localparam int CAT_BITS   = 5;
    localparam int MAX_CATS   = 32;
    localparam int CLASS_BITS = 8;
    localparam int STEP_BITS  = 10;
    localparam logic [STEP_BITS-1:0] MAX_STEPS = 10'd1000;

    localparam logic [1:0] OP_NODE  = 2'd0;
    localparam logic [1:0] OP_CATB  = 2'd1;
    localparam logic [1:0] OP_CATN  = 2'd2;
    localparam logic [1:0] OP_FEAT  = 2'd3;

    localparam logic [1:0] ST_TERMINAL = 2'd0;
    localparam logic [1:0] ST_SPLIT    = 2'd1;
    localparam logic [1:0] ST_UNSPLIT  = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    localparam logic CFG_FEATURE_COUNT  = 1'b0;
    localparam logic CFG_USE_CATEGORIES = 1'b1;

    // One node entry as stored in the node memory.
    typedef struct packed {
        logic [NODE_BITS-1:0]  left;
        logic [NODE_BITS-1:0]  right;
        logic [VAR_BITS-1:0]   var_sel;
        logic signed [31:0]    thresh;
        logic [1:0]            status;
        logic [CLASS_BITS-1:0] cls;
        logic [MAX_CATS-1:0]   cat_bits;
    } node_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_FEAT,
        S_NODE,
        S_OUT
    } state_t;

    // Write request into the node memory.
    typedef struct packed {
        logic                 node_we;
        logic                 bit_we;
        logic [NODE_BITS-1:0] addr;
        logic [CAT_BITS-1:0]  bit_sel;
        logic                 bit_val;
    } node_wr_t;

endpackage

>>> rtl/decision_tree_classify.sv
// Classification tree walker: top level with control sequencer,
// category count registers and output register. Depends on dtc_pkg,
// dtc_node_mem, dtc_sample_mem and decision_tree_classify_assert.svh.
//
// A user first loads a tree with write-node, write-category-bit and
// write-category-count words; each of these gives no result. Feature
// words store one Q16.16 value of the sample (positions at or above
// feature_count are dropped). A feature word marked last starts a
// walk from node 0 for an out-of-bag sample, or directly returns zeros for
// an in-bag sample. Each tree level of the walk needs one node memory read
// followed by one sample memory read of the split feature, and a walk
// stops when the step limit of 1000 moves is hit. Quantitative
// splits go left when the feature is at most the threshold; categorical
// splits (use_categories set and the variable's count above two) go left
// when the feature truncated toward zero is a category below the count
// whose bit is set. A walk that ends on an invalid node or hits the step
// limit answers the root class and node 0. The input is not ready while a
// walk runs or while a result waits in the output register and is not
// being taken in the same cycle. Node and sample memories are not cleared
// at reset; the category counts reset to zero.
`include "decision_tree_classify_assert.svh"

module decision_tree_classify (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [9:0]          node_index,
    input  logic [9:0]          left_child,
    input  logic [9:0]          right_child,
    input  logic [5:0]          var_index,
    input  logic signed [31:0]  value,
    input  logic [1:0]          node_status,
    input  logic [7:0]          node_class,
    input  logic [5:0]          category,
    input  logic                goes_left,
    input  logic                in_bag,
    input  logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          predicted_class,
    output logic [9:0]          end_node,
    output logic                out_of_bag
);
    localparam int NB = dtc_pkg::NODE_BITS;
    localparam int VB = dtc_pkg::VAR_BITS;

    dtc_pkg::state_t state_reg, state_next;

    logic [6:0]    feature_count_reg;
    logic          use_categories_reg;
    logic [VB-1:0] cat_count_reg [dtc_pkg::FEATURES];
    logic [VB-1:0] cnt_reg;

    logic [NB-1:0]                  cur_reg, cur_next;
    logic [dtc_pkg::STEP_BITS-1:0]  steps_reg, steps_next;
    logic [dtc_pkg::CLASS_BITS-1:0] root_class_reg, root_class_next;
    dtc_pkg::node_t                 cur_node_reg, cur_node_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     pclass_reg, pclass_next;
    logic [9:0]                     end_reg, end_next;
    logic                           oob_reg, oob_next;

    dtc_pkg::node_wr_t  nwr;
    dtc_pkg::node_t     nwdata;
    dtc_pkg::node_t     nrdata;
    logic               nrd_en;
    logic [NB-1:0]      nrd_addr;
    logic               feat_we;
    logic [VB-1:0]      feat_raddr;
    logic signed [31:0] feat_rdata;

    logic in_acc;
    assign in_ready  = (state_reg == dtc_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign nwr.node_we = in_acc && (op == dtc_pkg::OP_NODE);
    assign nwr.bit_we  = in_acc && (op == dtc_pkg::OP_CATB) && !category[5];
    assign nwr.addr    = node_index;
    assign nwr.bit_sel = category[dtc_pkg::CAT_BITS-1:0];
    assign nwr.bit_val = goes_left;

    assign nwdata.left     = left_child;
    assign nwdata.right    = right_child;
    assign nwdata.var_sel  = var_index;
    assign nwdata.thresh   = value;
    assign nwdata.status   = node_status;
    assign nwdata.cls      = node_class;
    assign nwdata.cat_bits = '0;

    assign feat_we = in_acc && (op == dtc_pkg::OP_FEAT)
                     && ({1'b0, var_index} < feature_count_reg);

    dtc_node_mem u_node (
        .clk     (clk),
        .wr      (nwr),
        .wdata   (nwdata),
        .rd_en   (nrd_en),
        .rd_addr (nrd_addr),
        .rdata   (nrdata)
    );

    // The split feature is addressed from the node row about to be
    // registered, so the feature arrives together with its node.
    assign feat_raddr = cur_node_next.var_sel;

    dtc_sample_mem u_sample (
        .clk   (clk),
        .we    (feat_we),
        .waddr (var_index),
        .wdata (value),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg  <= 7'd64;
            use_categories_reg <= 1'b0;
            for (int i = 0; i < dtc_pkg::FEATURES; i++)
            begin
                cat_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_index == dtc_pkg::CFG_FEATURE_COUNT)
            begin
                feature_count_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == dtc_pkg::CFG_USE_CATEGORIES)
            begin
                use_categories_reg <= cfg_data[0];
            end
            if (in_acc && op == dtc_pkg::OP_CATN)
            begin
                cat_count_reg[var_index] <= category;
            end
        end
    end

    // Branch decision for the node in cur_node_reg with its feature.
    logic [VB-1:0]   cnt;
    logic            is_cat;
    logic            cat_left;
    logic [15:0]     cat_int;
    logic [NB-1:0]   child;
    always_comb
    begin
        cnt      = cnt_reg;
        is_cat   = use_categories_reg && (cnt > 6'd2);
        cat_int  = feat_rdata[31] ? 16'd0 : feat_rdata[31:16];
        cat_left = 1'b0;
        if (feat_rdata <= -32'sd65536)
        begin
            cat_left = 1'b0;
        end
        else if (cat_int < {10'd0, cnt} && cat_int < 16'd32)
        begin
            cat_left = cur_node_reg.cat_bits[cat_int[dtc_pkg::CAT_BITS-1:0]];
        end
        if (is_cat)
        begin
            child = cat_left ? cur_node_reg.left : cur_node_reg.right;
        end
        else
        begin
            child = (feat_rdata <= cur_node_reg.thresh)
                    ? cur_node_reg.left : cur_node_reg.right;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        root_class_next = root_class_reg;
        cur_node_next   = cur_node_reg;
        out_valid_next  = out_valid_reg;
        pclass_next     = pclass_reg;
        end_next        = end_reg;
        oob_next        = oob_reg;
        nrd_en          = 1'b0;
        nrd_addr        = cur_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            dtc_pkg::S_IDLE:
            begin
                if (in_acc && op == dtc_pkg::OP_FEAT && last)
                begin
                    if (in_bag)
                    begin
                        out_valid_next = 1'b1;
                        pclass_next    = '0;
                        end_next       = '0;
                        oob_next       = 1'b0;
                    end
                    else
                    begin
                        nrd_en     = 1'b1;
                        nrd_addr   = '0;
                        cur_next   = '0;
                        steps_next = '0;
                        state_next = dtc_pkg::S_ROOT;
                    end
                end
            end
            dtc_pkg::S_ROOT:
            begin
                root_class_next = nrdata.cls;
                cur_node_next   = nrdata;
                state_next      = (nrdata.status == dtc_pkg::ST_SPLIT)
                                  ? dtc_pkg::S_FEAT : dtc_pkg::S_OUT;
            end
            dtc_pkg::S_FEAT:
            begin
                nrd_en     = 1'b1;
                nrd_addr   = child;
                cur_next   = child;
                steps_next = steps_reg + 1'b1;
                state_next = dtc_pkg::S_NODE;
            end
            dtc_pkg::S_NODE:
            begin
                cur_node_next = nrdata;
                if (nrdata.status == dtc_pkg::ST_SPLIT && steps_reg < dtc_pkg::MAX_STEPS)
                begin
                    state_next = dtc_pkg::S_FEAT;
                end
                else
                begin
                    state_next = dtc_pkg::S_OUT;
                end
            end
            dtc_pkg::S_OUT:
            begin
                out_valid_next = 1'b1;
                oob_next       = 1'b1;
                if (cur_node_reg.status == dtc_pkg::ST_TERMINAL
                    || cur_node_reg.status == dtc_pkg::ST_UNSPLIT)
                begin
                    pclass_next = cur_node_reg.cls;
                    end_next    = cur_reg;
                end
                else
                begin
                    pclass_next = root_class_reg;
                    end_next    = '0;
                end
                state_next = dtc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dtc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        root_class_reg <= root_class_next;
        cur_node_reg   <= cur_node_next;
        cnt_reg        <= cat_count_reg[feat_raddr];
        pclass_reg     <= pclass_next;
        end_reg        <= end_next;
        oob_reg        <= oob_next;
    end

    assign out_valid       = out_valid_reg;
    assign predicted_class = pclass_reg;
    assign end_node        = end_reg;
    assign out_of_bag      = oob_reg;

    `DTC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != dtc_pkg::S_IDLE, !in_ready, "input taken during a walk")
    `DTC_ASSERT_NEXT(a_out_from_walk, clk, rst_n, state_reg == dtc_pkg::S_OUT, out_valid_reg && oob_reg, "walk ended without a result")
    `DTC_ASSERT_IMP(a_step_limit, clk, rst_n, state_reg == dtc_pkg::S_NODE, steps_reg <= dtc_pkg::MAX_STEPS, "step count beyond limit")
    `DTC_ASSERT_IMP(a_bag_zero, clk, rst_n, out_valid_reg && !oob_reg, pclass_reg == 8'd0 && end_reg == 10'd0, "in-bag result not zero")

endmodule

>>> rtl/dtc_node_mem.sv
// Node memory of the classification tree: links, split data, class and
// the left-going category bits, one row per node. Depends on dtc_pkg.
module dtc_node_mem (
    input  logic                          clk,
    input  dtc_pkg::node_wr_t             wr,
    input  dtc_pkg::node_t                wdata,
    input  logic                          rd_en,
    input  logic [dtc_pkg::NODE_BITS-1:0] rd_addr,
    output dtc_pkg::node_t                rdata
);
    dtc_pkg::node_t mem [dtc_pkg::NODES];
    dtc_pkg::node_t rdata_reg;

    // Category bits use a bit-enable write so one bit can change alone.
    always_ff @(posedge clk)
    begin
        if (wr.node_we)
        begin
            mem[wr.addr].left    <= wdata.left;
            mem[wr.addr].right   <= wdata.right;
            mem[wr.addr].var_sel <= wdata.var_sel;
            mem[wr.addr].thresh  <= wdata.thresh;
            mem[wr.addr].status  <= wdata.status;
            mem[wr.addr].cls     <= wdata.cls;
        end
        if (wr.bit_we)
        begin
            mem[wr.addr].cat_bits[wr.bit_sel] <= wr.bit_val;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/dtc_sample_mem.sv
// Sample row memory holding the current sample's Q16.16 features.
// Depends on dtc_pkg.
module dtc_sample_mem (
    input  logic                         clk,
    input  logic                         we,
    input  logic [dtc_pkg::VAR_BITS-1:0] waddr,
    input  logic signed [31:0]           wdata,
    input  logic [dtc_pkg::VAR_BITS-1:0] raddr,
    output logic signed [31:0]           rdata
);
    logic signed [31:0] mem [dtc_pkg::FEATURES];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> sim/decision_tree_classify_tb.sv
// Self-checking testbench for the classification tree walker decision_tree_classify.
// Depends on dtc_pkg and the RTL in rtl; needs no files or arguments at run time.
// Loads random trees and samples, predicts each result and compares on the fly.
module decision_tree_classify_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One input word as the sender presents it.
    typedef struct {
        logic [1:0]         op;
        logic [9:0]         node_index;
        logic [9:0]         left_child;
        logic [9:0]         right_child;
        logic [5:0]         var_index;
        logic signed [31:0] value;
        logic [1:0]         node_status;
        logic [7:0]         node_class;
        logic [5:0]         category;
        logic               goes_left;
        logic               in_bag;
        logic               last;
    } word_t;

    // One classification result.
    typedef struct {
        logic [7:0] cls;
        logic [9:0] node;
        logic       oob;
    } verdict_t;

    // A directed row: the word, and a hand-typed verdict where one applies.
    typedef struct {
        word_t    w;
        bit       typed;
        verdict_t v;
    } step_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = '0;
    logic [9:0]         node_index = '0;
    logic [9:0]         left_child = '0;
    logic [9:0]         right_child = '0;
    logic [5:0]         var_index = '0;
    logic signed [31:0] value = '0;
    logic [1:0]         node_status = '0;
    logic [7:0]         node_class = '0;
    logic [5:0]         category = '0;
    logic               goes_left = 1'b0;
    logic               in_bag = 1'b0;
    logic               last = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [6:0]         cfg_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         predicted_class;
    logic [9:0]         end_node;
    logic               out_of_bag;

    decision_tree_classify u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block's state, kept by the tree predictor.
    // ------------------------------------------------------------------
    logic [9:0]                   lnk_l    [dtc_pkg::NODES];
    logic [9:0]                   lnk_r    [dtc_pkg::NODES];
    logic [5:0]                   split_var[dtc_pkg::NODES];
    logic signed [31:0]           thresh   [dtc_pkg::NODES];
    logic [1:0]                   node_st  [dtc_pkg::NODES];
    logic [7:0]                   node_cls [dtc_pkg::NODES];
    bit [dtc_pkg::MAX_CATS-1:0]   cat_bit  [dtc_pkg::NODES];
    logic [5:0]                   cat_count[dtc_pkg::FEATURES];
    logic signed [31:0]           row_val  [dtc_pkg::FEATURES];
    bit                           feat_ok  [dtc_pkg::FEATURES];   // positions holding a value
    logic [6:0]                   feat_count;
    logic                         use_cats;

    verdict_t expected_verdicts[$];
    int       fails = 0;
    int       words_sent = 0;
    int       in_idle = 24;
    int       out_idle = 66;
    int       hold_req = 0;
    int       hold_left = 0;

    // One move down the tree from split node kt.
    function automatic logic [9:0] next_hop(logic [9:0] kt);
        logic [5:0]         v;
        logic signed [31:0] x;
        logic [5:0]         cnt;
        int                 c;
        v = split_var[kt];
        x = row_val[v];
        cnt = cat_count[v];
        if (!use_cats || cnt <= 2)
            return (x <= thresh[kt]) ? lnk_l[kt] : lnk_r[kt];
        // Categories truncate toward zero; anything at or below -1.0 goes right.
        if (x <= -32'sd65536)
            return lnk_r[kt];
        c = (x < 0) ? 0 : int'(x >>> 16);
        if (c < cnt && c < dtc_pkg::MAX_CATS && cat_bit[kt][c])
            return lnk_l[kt];
        return lnk_r[kt];
    endfunction

    // Applies one word to the shadow state; returns 1 when it yields a verdict.
    function automatic bit classify_word(word_t w, output verdict_t r);
        int         steps;
        logic [9:0] kt;
        r = '{cls: '0, node: '0, oob: 1'b0};
        case (w.op)
            dtc_pkg::OP_NODE:
            begin
                lnk_l[w.node_index]     = w.left_child;
                lnk_r[w.node_index]     = w.right_child;
                split_var[w.node_index] = w.var_index;
                thresh[w.node_index]    = w.value;
                node_st[w.node_index]   = w.node_status;
                node_cls[w.node_index]  = w.node_class;
                return 0;
            end
            dtc_pkg::OP_CATB:
            begin
                if (w.category < dtc_pkg::MAX_CATS)
                    cat_bit[w.node_index][w.category[4:0]] = w.goes_left;
                return 0;
            end
            dtc_pkg::OP_CATN:
            begin
                cat_count[w.var_index] = w.category;
                return 0;
            end
            default:
            begin
                if (w.var_index < feat_count)
                begin
                    row_val[w.var_index] = w.value;
                    feat_ok[w.var_index] = 1'b1;
                end
                if (!w.last)
                    return 0;
                if (w.in_bag)
                    return 1;
                kt = '0;
                steps = 0;
                while (node_st[kt] == dtc_pkg::ST_SPLIT && steps < int'(dtc_pkg::MAX_STEPS))
                begin
                    steps++;
                    kt = next_hop(kt);
                    if (node_st[kt] != dtc_pkg::ST_SPLIT)
                        break;
                end
                // Invalid ends and step-limit hits fall back to the root.
                if (node_st[kt] == dtc_pkg::ST_TERMINAL || node_st[kt] == dtc_pkg::ST_UNSPLIT)
                    r = '{cls: node_cls[kt], node: kt, oob: 1'b1};
                else
                    r = '{cls: node_cls[0], node: '0, oob: 1'b1};
                return 1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                e = expected_verdicts.pop_front();
                if (predicted_class !== e.cls)
                    report_mismatch("predicted_class", predicted_class, e.cls);
                if (end_node !== e.node)
                    report_mismatch("end_node", end_node, e.node);
                if (out_of_bag !== e.oob)
                    report_mismatch("out_of_bag", out_of_bag, e.oob);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so that the
    // output register stays full and the block backs up its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= out_idle);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Sends one word; the verdict is predicted at acceptance, or taken as typed.
    task automatic send_word(word_t w, bit typed = 0,
                             verdict_t tv = '{cls: '0, node: '0, oob: 1'b0});
        verdict_t r;
        // Idle schedule: sender light and receiver heavy, then the reverse, then none.
        if (words_sent < 430)
        begin
            in_idle = 24;
            out_idle = 66;
        end
        else if (words_sent < 860)
        begin
            in_idle = 66;
            out_idle = 24;
        end
        else
        begin
            in_idle = 0;
            out_idle = 0;
        end
        while ($urandom_range(99) < in_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w.op;
        node_index  <= w.node_index;
        left_child  <= w.left_child;
        right_child <= w.right_child;
        var_index   <= w.var_index;
        value       <= w.value;
        node_status <= w.node_status;
        node_class  <= w.node_class;
        category    <= w.category;
        goes_left   <= w.goes_left;
        in_bag      <= w.in_bag;
        last        <= w.last;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (classify_word(w, r))
            expected_verdicts.push_back(typed ? tv : r);
    endtask

    // Waits until every expected verdict has come and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(logic idx, logic [6:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == dtc_pkg::CFG_FEATURE_COUNT)
            feat_count = d;
        else
            use_cats = d[0];
    endtask

    // Q16.16 values that hit both signs, category-sized integers and the
    // boundaries around minus one.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return {16'($urandom_range(0, 9)), 16'($urandom)};
            2: return -32'sd1 * $urandom_range(1, 65535);
            3: return -32'sd65536 - $urandom_range(0, 200000);
            4: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return {16'($urandom_range(0, 33)), 16'h0};
        endcase
    endfunction

    function automatic word_t rand_word(logic [1:0] o);
        word_t w;
        w.op          = o;
        w.node_index  = $urandom;
        w.left_child  = $urandom;
        w.right_child = $urandom;
        w.var_index   = $urandom;
        w.value       = $urandom;
        w.node_status = $urandom;
        w.node_class  = $urandom;
        w.category    = $urandom_range(0, 32);
        w.goes_left   = $urandom;
        w.in_bag      = $urandom;
        w.last        = 1'b0;
        return w;
    endfunction

    function automatic word_t mk(logic [1:0] o, logic [9:0] n, logic [9:0] l,
                                 logic [9:0] r, logic [5:0] v, logic signed [31:0] x,
                                 logic [1:0] s, logic [7:0] c, logic [5:0] cat,
                                 logic gl, logic ib, logic lst);
        word_t w;
        w = '{op: o, node_index: n, left_child: l, right_child: r, var_index: v,
              value: x, node_status: s, node_class: c, category: cat,
              goes_left: gl, in_bag: ib, last: lst};
        return w;
    endfunction

    // Category counts on a few variables, plus an ignored out-of-range bit write.
    task automatic load_counts(int maxc);
        word_t w;
        repeat (8)
        begin
            w = rand_word(dtc_pkg::OP_CATN);
            w.category = $urandom_range(0, maxc);
            send_word(w);
        end
        w = rand_word(dtc_pkg::OP_CATB);
        w.category = dtc_pkg::MAX_CATS;
        send_word(w);
    endtask

    // Every feature position once; those at or above feature_count are dropped.
    task automatic load_row();
        word_t w;
        for (int v = 0; v < dtc_pkg::FEATURES; v++)
        begin
            w = rand_word(dtc_pkg::OP_FEAT);
            w.var_index = v;
            w.value = pick_value();
            send_word(w);
        end
    endtask

    // Writes a random tree on k nodes whose links stay inside the written set,
    // so no walk ever reads a node, bit or feature that was never loaded.
    task automatic build_tree(int k, bit all_split);
        logic [9:0] ids[$];
        int         vars_ok[$];
        bit         used[dtc_pkg::NODES];
        logic [9:0] n;
        int         need;
        int         r;
        word_t      w;
        ids.push_back(0);
        used[0] = 1'b1;
        if ($urandom_range(1))
        begin
            ids.push_back(dtc_pkg::NODES - 1);
            used[dtc_pkg::NODES - 1] = 1'b1;
        end
        while (ids.size() < k)
        begin
            n = $urandom_range(1, dtc_pkg::NODES - 1);
            if (!used[n])
            begin
                used[n] = 1'b1;
                ids.push_back(n);
            end
        end
        for (int v = 0; v < dtc_pkg::FEATURES; v++)
            if (feat_ok[v])
                vars_ok.push_back(v);
        need = 0;
        if (use_cats)
            for (int v = 0; v < dtc_pkg::FEATURES; v++)
                if (cat_count[v] > need)
                    need = cat_count[v];
        if (need > dtc_pkg::MAX_CATS)
            need = dtc_pkg::MAX_CATS;
        foreach (ids[i])
        begin
            w = rand_word(dtc_pkg::OP_NODE);
            w.node_index  = ids[i];
            w.left_child  = ids[$urandom_range(0, ids.size() - 1)];
            w.right_child = ids[$urandom_range(0, ids.size() - 1)];
            w.var_index   = vars_ok[$urandom_range(0, vars_ok.size() - 1)];
            w.value       = pick_value();
            r = $urandom_range(99);
            if (all_split || r < 45)
                w.node_status = dtc_pkg::ST_SPLIT;
            else if (r < 65)
                w.node_status = dtc_pkg::ST_TERMINAL;
            else if (r < 85)
                w.node_status = dtc_pkg::ST_UNSPLIT;
            else
                w.node_status = dtc_pkg::ST_INVALID;
            send_word(w);
            if (w.node_status == dtc_pkg::ST_SPLIT)
                for (int c = 0; c < need; c++)
                begin
                    w = rand_word(dtc_pkg::OP_CATB);
                    w.node_index = ids[i];
                    w.category = c;
                    send_word(w);
                end
        end
    endtask

    // Samples: a few feature updates, then a last one that walks unless in bag.
    task automatic run_samples(int count);
        word_t w;
        repeat (count)
        begin
            repeat ($urandom_range(0, 3))
            begin
                w = rand_word(dtc_pkg::OP_FEAT);
                w.value = pick_value();
                send_word(w);
            end
            w = rand_word(dtc_pkg::OP_FEAT);
            w.value = pick_value();
            w.last = 1'b1;
            w.in_bag = ($urandom_range(9) == 0);
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        step_row_t tab[17];
        verdict_t  none;
        none = '{cls: '0, node: '0, oob: 1'b0};

        feat_count = 7'd64;
        use_cats = 1'b0;
        foreach (cat_count[i])
            cat_count[i] = '0;

        // Directed part. Only nodes 0 and 1023 are ever reached here.
        tab[0]  = '{mk(dtc_pkg::OP_FEAT, 0, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 0),
                    0, none};
        tab[1]  = '{mk(dtc_pkg::OP_FEAT, 1023, 1023, 1023, 63, 32'sh80000000, 3, 255, 32,
                       1, 1, 0), 0, none};
        // An in-bag sample answers zeros without touching the tree.
        tab[2]  = '{mk(dtc_pkg::OP_FEAT, 0, 0, 0, 5, -1, 0, 0, 0, 0, 1, 1), 1, none};
        tab[3]  = '{mk(dtc_pkg::OP_NODE, 0, 1023, 0, 63, 32'sh80000000, dtc_pkg::ST_TERMINAL,
                       255, 0, 0, 0, 0), 0, none};
        // Terminal root: class of the root, node 0.
        tab[4]  = '{mk(dtc_pkg::OP_FEAT, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1), 1,
                    '{8'd255, 10'd0, 1'b1}};
        tab[5]  = '{mk(dtc_pkg::OP_NODE, 1023, 0, 0, 0, 0, dtc_pkg::ST_TERMINAL, 7, 0, 0, 0, 0),
                    0, none};
        tab[6]  = '{mk(dtc_pkg::OP_NODE, 0, 1023, 1023, 0, 32'sh7fffffff, dtc_pkg::ST_SPLIT,
                       8'ha5, 0, 0, 0, 0), 0, none};
        // Feature equal to the threshold; both links lead to node 1023, where the walk ends.
        tab[7]  = '{mk(dtc_pkg::OP_FEAT, 0, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 1), 1,
                    '{8'd7, 10'd1023, 1'b1}};
        // Root splits back to itself: the step limit forces the fallback.
        tab[8]  = '{mk(dtc_pkg::OP_NODE, 0, 1023, 0, 0, 32'sh7ffffffe, dtc_pkg::ST_SPLIT,
                       8'h5a, 0, 0, 0, 0), 0, none};
        tab[9]  = '{mk(dtc_pkg::OP_FEAT, 0, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 1), 1,
                    '{8'h5a, 10'd0, 1'b1}};
        // Walk ending on an invalid node falls back to the root.
        tab[10] = '{mk(dtc_pkg::OP_NODE, 1023, 0, 0, 0, 0, dtc_pkg::ST_INVALID, 3, 0, 0, 0, 0),
                    0, none};
        tab[11] = '{mk(dtc_pkg::OP_NODE, 0, 1023, 1023, 0, 32'sh80000000, dtc_pkg::ST_SPLIT,
                       8'h11, 0, 0, 0, 0), 0, none};
        tab[12] = '{mk(dtc_pkg::OP_FEAT, 0, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 1), 1,
                    '{8'h11, 10'd0, 1'b1}};
        tab[13] = '{mk(dtc_pkg::OP_NODE, 1023, 0, 0, 0, 0, dtc_pkg::ST_UNSPLIT, 8'h80,
                       0, 0, 0, 0), 0, none};
        // Unsplit end node answers its own class and index.
        tab[14] = '{mk(dtc_pkg::OP_FEAT, 0, 0, 0, 0, 32'sh80000000, 0, 0, 0, 0, 0, 1), 1,
                    '{8'h80, 10'd1023, 1'b1}};
        // Category bit writes at the top of the range; the second is ignored.
        tab[15] = '{mk(dtc_pkg::OP_CATB, 0, 0, 0, 0, 0, 0, 0, 31, 1, 0, 0), 0, none};
        tab[16] = '{mk(dtc_pkg::OP_CATB, 0, 0, 0, 0, 0, 0, 0, 32, 1, 0, 0), 0, none};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tab[i])
            send_word(tab[i].w, tab[i].typed, tab[i].v);

        // Random phases, each under its own register setting.
        write_reg(dtc_pkg::CFG_FEATURE_COUNT, 7'd64);
        write_reg(dtc_pkg::CFG_USE_CATEGORIES, 7'd1);
        load_counts(6);
        load_row();
        build_tree($urandom_range(3, 12), 1'b0);
        run_samples(30);

        write_reg(dtc_pkg::CFG_FEATURE_COUNT, 7'd1);
        load_counts(8);
        load_row();
        build_tree($urandom_range(3, 12), 1'b0);
        // Long receiver hold-off while the sender keeps offering words.
        hold_req = 400;
        run_samples(40);

        write_reg(dtc_pkg::CFG_FEATURE_COUNT, 7'd40);
        write_reg(dtc_pkg::CFG_USE_CATEGORIES, 7'd0);
        load_row();
        build_tree($urandom_range(3, 12), 1'b0);
        run_samples(40);
        build_tree($urandom_range(2, 6), 1'b1);   // every walk hits the step limit
        run_samples(6);

        write_reg(dtc_pkg::CFG_FEATURE_COUNT, 7'd64);
        load_row();
        build_tree($urandom_range(8, 16), 1'b0);
        run_samples(40);

        write_reg(dtc_pkg::CFG_FEATURE_COUNT, 7'd17);
        write_reg(dtc_pkg::CFG_USE_CATEGORIES, 7'd1);
        load_row();
        build_tree($urandom_range(3, 12), 1'b0);
        run_samples(40);

        write_reg(dtc_pkg::CFG_FEATURE_COUNT, 7'd64);
        load_counts(32);
        load_row();
        build_tree($urandom_range(3, 7), 1'b0);
        run_samples(45);

        drain();
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #24_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
